@@ hw/rtl/utn_pkg.sv @@
// Shared constants, types and helpers for the utterance text normalizer.
// No dependencies; compiled first.
package utn_pkg;

  localparam int unsigned WORD_DEPTH = 32;
  localparam int unsigned ADDR_W     = $clog2(WORD_DEPTH);
  localparam int unsigned LEN_W      = $clog2(WORD_DEPTH + 1);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OPS_N      = 3;
  localparam int unsigned OPS_CW     = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [OPS_CW-1:0] opcnt_t;

  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_BANG   = 8'h21;
  localparam byte_t CH_HASH   = 8'h23;
  localparam byte_t CH_APOS   = 8'h27;
  localparam byte_t CH_LPAR   = 8'h28;
  localparam byte_t CH_RPAR   = 8'h29;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_HYPHEN = 8'h2D;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_QUEST  = 8'h3F;
  localparam byte_t CH_LBRK   = 8'h5B;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_RBRK   = 8'h5D;
  localparam byte_t CH_LOW_A  = 8'h61;
  localparam byte_t CH_LOW_Z  = 8'h7A;
  localparam byte_t CASE_OFS  = 8'h20;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_NEXT = 6'b000010,
    ST_EMIT = 6'b000100,
    ST_TERM = 6'b001000,
    ST_DRD  = 6'b010000,
    ST_DWR  = 6'b100000
  } state_e;

  function automatic logic is_ws(byte_t b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

@@ hw/rtl/utn_if.sv @@
// Valid/ready stream interfaces for the normalizer's input and output channels.
// Depends on utn_pkg.
interface utn_in_if import utn_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  line_end;

  modport source (output valid, in_byte, line_end, input ready);
  modport sink   (input valid, in_byte, line_end, output ready);
endinterface

interface utn_out_if import utn_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;
  logic  word_overflow;

  modport source (output valid, out_byte, out_last, word_overflow, input ready);
  modport sink   (input valid, out_byte, out_last, word_overflow, output ready);
endinterface

@@ hw/rtl/utterance_text_normalizer.sv @@
// Utterance text normalizer: one raw byte in, zero or more normalized bytes out.
// Depends on utn_pkg and the utn_in_if / utn_out_if stream interfaces.
// An input transaction is taken only in idle. The sequencer then stores or emits each
// decoded character in turn and ends a line with the terminator; a word flush (also
// forced when the store is full) streams the held word from the one-read-port word
// memory, one byte per cycle while the output is not stalled. The output register
// decouples the consumer; a stall on the output holds the sequencer.
// No clearing pass after reset.
module utterance_text_normalizer import utn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  utn_in_if.sink    in_i,
  utn_out_if.source out_o
);

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  len_t   len_q, len_d;
  len_t   idx_q, idx_d;
  len_t   idx_nxt;
  logic   hp_q, hp_d;
  logic   ic_q, ic_d;
  logic   se_q, se_d;
  logic   end_q, end_d;
  logic   ovf_q, ovf_d;
  opcnt_t cnt_q, cnt_d;
  byte_t  ops_q [OPS_N];
  byte_t  ops_d [OPS_N];

  logic   out_valid_q, out_valid_d;
  byte_t  out_byte_q, out_byte_d;
  logic   out_last_q, out_last_d;
  logic   out_ovf_q, out_ovf_d;
  logic   out_free;

  byte_t  word_store_q [WORD_DEPTH];
  byte_t  rdata_q;
  logic   we, re;
  addr_t  waddr, raddr;
  byte_t  wdata;

  opcnt_t dec_cnt;
  byte_t  dec_ops [OPS_N];
  logic   dec_clr, dec_hp, dec_ic;
  byte_t  b;
  logic   in_acc;

  assign b        = in_i.in_byte;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_nxt  = idx_q + len_t'(1);

  // Decode one input byte into up to three character operations.
  always_comb begin
    dec_cnt = '0;
    dec_ops = '{default: CH_SPACE};
    dec_clr = 1'b0;
    dec_hp  = 1'b0;
    dec_ic  = ic_q;
    if (hp_q) begin
      if (is_ws(b)) begin
        dec_clr = 1'b1;
        if (!se_q) begin
          dec_ops[dec_cnt] = CH_SPACE;
          dec_cnt          = dec_cnt + opcnt_t'(1);
        end
      end else begin
        dec_ops[dec_cnt] = CH_HYPHEN;
        dec_cnt          = dec_cnt + opcnt_t'(1);
      end
    end
    if (ic_q) begin
      if (b == CH_HASH) begin
        dec_ic = 1'b0;
      end
    end else begin
      case (b)
        CH_NUL, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK,
        CH_COLON, CH_SEMI, CH_QUEST, CH_BANG, CH_LF: begin
        end
        CH_COMMA, CH_BSLASH: begin
          dec_ops[dec_cnt] = CH_SPACE;
          dec_cnt          = dec_cnt + opcnt_t'(1);
        end
        CH_HASH: begin
          dec_ic = 1'b1;
        end
        CH_HYPHEN: begin
          if (in_i.line_end) begin
            dec_ops[dec_cnt] = CH_HYPHEN;
            dec_cnt          = dec_cnt + opcnt_t'(1);
          end else begin
            dec_hp = 1'b1;
          end
        end
        CH_DOT, CH_APOS: begin
          dec_ops[dec_cnt] = CH_SPACE;
          dec_cnt          = dec_cnt + opcnt_t'(1);
          dec_ops[dec_cnt] = b;
          dec_cnt          = dec_cnt + opcnt_t'(1);
        end
        default: begin
          dec_ops[dec_cnt] = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? (b - CASE_OFS) : b;
          dec_cnt          = dec_cnt + opcnt_t'(1);
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    len_d       = len_q;
    idx_d       = idx_q;
    hp_d        = hp_q;
    ic_d        = ic_q;
    se_d        = se_q;
    end_d       = end_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    ops_d       = ops_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    we          = 1'b0;
    waddr       = len_q[ADDR_W-1:0];
    wdata       = ops_q[0];
    re          = 1'b0;
    raddr       = idx_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ops_d   = dec_ops;
          cnt_d   = dec_cnt;
          hp_d    = dec_hp;
          ic_d    = dec_ic;
          end_d   = in_i.line_end;
          if (dec_clr) begin
            len_d = '0;
          end
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (cnt_q != '0) begin
          if (is_ws(ops_q[0])) begin
            if (len_q != '0) begin
              ovf_d   = 1'b0;
              idx_d   = '0;
              ret_d   = ST_EMIT;
              state_d = ST_DRD;
            end else begin
              state_d = ST_EMIT;
            end
          end else if (len_q == len_t'(WORD_DEPTH)) begin
            ovf_d   = 1'b1;
            idx_d   = '0;
            ret_d   = ST_NEXT;
            state_d = ST_DRD;
          end else begin
            we       = 1'b1;
            len_d    = len_q + len_t'(1);
            ops_d[0] = ops_q[1];
            ops_d[1] = ops_q[2];
            cnt_d    = cnt_q - opcnt_t'(1);
          end
        end else if (end_q) begin
          if (len_q != '0) begin
            ovf_d   = 1'b0;
            idx_d   = '0;
            ret_d   = ST_TERM;
            state_d = ST_DRD;
          end else begin
            state_d = ST_TERM;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRD: begin
        re      = 1'b1;
        state_d = ST_DWR;
      end
      ST_DWR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          out_last_d  = 1'b0;
          out_ovf_d   = ovf_q;
          if (idx_nxt == len_q) begin
            len_d   = '0;
            state_d = ret_q;
          end else begin
            idx_d = idx_nxt;
            re    = 1'b1;
            raddr = idx_nxt[ADDR_W-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = ops_q[0];
          out_last_d  = 1'b0;
          out_ovf_d   = 1'b0;
          se_d        = 1'b1;
          ops_d[0]    = ops_q[1];
          ops_d[1]    = ops_q[2];
          cnt_d       = cnt_q - opcnt_t'(1);
          state_d     = ST_NEXT;
        end
      end
      ST_TERM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = CH_NUL;
          out_last_d  = 1'b1;
          out_ovf_d   = 1'b0;
          hp_d        = 1'b0;
          ic_d        = 1'b0;
          se_d        = 1'b0;
          end_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      len_q       <= '0;
      hp_q        <= 1'b0;
      ic_q        <= 1'b0;
      se_q        <= 1'b0;
      end_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      len_q       <= len_d;
      hp_q        <= hp_d;
      ic_q        <= ic_d;
      se_q        <= se_d;
      end_q       <= end_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    ovf_q      <= ovf_d;
    ops_q      <= ops_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Word memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      word_store_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= word_store_q[raddr];
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.out_last      = out_last_q;
  assign out_o.word_overflow = out_ovf_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= len_t'(WORD_DEPTH))
    else $error("word length above store depth");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DWR) |-> (len_q != '0) && (idx_q < len_q))
    else $error("drain beyond held word");

  a_term_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_byte_q == CH_NUL) && !out_ovf_q)
    else $error("terminator carries data or overflow");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q == '0) && !end_q)
    else $error("transaction taken with work pending");

  a_line_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM && out_free) |=> !hp_q && !ic_q && !se_q && (len_q == '0))
    else $error("line state not cleared after terminator");

endmodule

@@ bench/utterance_text_normalizer_tb.sv @@
// Testbench for utterance_text_normalizer: a table of directed bytes, then random
// lines under four idle/stall mixes, every output checked against table entries or a built-in model.
// Depends on utn_pkg, utn_in_if / utn_out_if and the normalizer RTL.
module utterance_text_normalizer_tb;
  import utn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 75;

  localparam byte_t PUNCT [10] = '{CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_COLON,
                                   CH_SEMI, CH_QUEST, CH_BANG, CH_COMMA, CH_BSLASH};

  typedef struct packed {
    byte_t ch;
    logic  last;
    logic  ovf;
  } norm_char_t;

  // n < 0: results come from the model; otherwise the first n entries of r
  typedef struct {
    byte_t      c;
    logic       fin;
    int         n;
    norm_char_t r [3];
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  utn_in_if  in_if ();
  utn_out_if out_if ();

  utterance_text_normalizer u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  // model state
  byte_t       word_buf [WORD_DEPTH];
  int unsigned word_cnt  = 0;
  bit          hy_wait   = 1'b0;
  bit          in_note   = 1'b0;
  bit          space_out = 1'b0;

  norm_char_t  step_q [$];
  norm_char_t  norm_q [$];
  stim_row_t   dir_q [$];
  byte_t       line_q [$];

  int          err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          long_hold_go  = 1'b0;
  bit          hold_armed    = 1'b0;
  int unsigned hold_left     = 0;

  function automatic bit blank(byte_t c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic norm_char_t plain(byte_t c, logic last);
    return '{ch: c, last: last, ovf: 1'b0};
  endfunction

  function automatic void flush_word(logic ovf);
    for (int unsigned i = 0; i < word_cnt; i++) begin
      step_q.push_back('{ch: word_buf[i], last: 1'b0, ovf: ovf});
    end
    word_cnt = 0;
  endfunction

  function automatic void put_out(byte_t c);
    if (blank(c)) begin
      flush_word(1'b0);
      step_q.push_back(plain(c, 1'b0));
      space_out = 1'b1;
    end else begin
      if (word_cnt >= WORD_DEPTH) flush_word(1'b1);
      word_buf[word_cnt] = c;
      word_cnt++;
    end
  endfunction

  // fills step_q with the bytes one input transaction produces
  function automatic void normalize(byte_t c, logic fin);
    step_q.delete();
    if (hy_wait) begin
      hy_wait = 1'b0;
      if (blank(c)) begin
        word_cnt = 0;
        if (!space_out) put_out(CH_SPACE);
      end else begin
        put_out(CH_HYPHEN);
      end
    end
    if (in_note) begin
      if (c == CH_HASH) in_note = 1'b0;
    end else begin
      case (c)
        CH_NUL, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK,
        CH_COLON, CH_SEMI, CH_QUEST, CH_BANG, CH_LF: ;
        CH_COMMA, CH_BSLASH: put_out(CH_SPACE);
        CH_HASH: in_note = 1'b1;
        CH_HYPHEN: begin
          if (fin) put_out(CH_HYPHEN);
          else hy_wait = 1'b1;
        end
        CH_DOT, CH_APOS: begin
          put_out(CH_SPACE);
          put_out(c);
        end
        default: put_out((c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c);
      endcase
    end
    if (fin) begin
      flush_word(1'b0);
      step_q.push_back(plain(CH_NUL, 1'b1));
      hy_wait   = 1'b0;
      in_note   = 1'b0;
      space_out = 1'b0;
    end
  endfunction

  function automatic void add_row(byte_t c, logic fin, int n, norm_char_t r0 = '0,
                                  norm_char_t r1 = '0, norm_char_t r2 = '0);
    stim_row_t row;
    row.c    = c;
    row.fin  = fin;
    row.n    = n;
    row.r[0] = r0;
    row.r[1] = r1;
    row.r[2] = r2;
    dir_q.push_back(row);
  endfunction

  function automatic byte_t word_char();
    case ($urandom_range(0, 5))
      0, 1, 2, 3: return byte_t'($urandom_range(CH_LOW_A, CH_LOW_Z));
      4:          return byte_t'($urandom_range(CH_LOW_A, CH_LOW_Z)) - CASE_OFS;
      default:    return byte_t'($urandom_range(8'h30, 8'hFF));
    endcase
  endfunction

  function automatic byte_t blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : byte_t'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic void gen_line();
    int target;
    int len;
    line_q.delete();
    target = $urandom_range(1, 30);
    while (line_q.size() < target) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 70) : $urandom_range(1, 8);
          repeat (len) line_q.push_back(word_char());
        end
        4: line_q.push_back(blank_char());
        5: begin
          line_q.push_back(CH_HYPHEN);
          if ($urandom_range(0, 2) != 0) line_q.push_back(blank_char());
        end
        6: line_q.push_back(PUNCT[$urandom_range(0, 9)]);
        7: begin
          line_q.push_back(CH_HASH);
          repeat ($urandom_range(0, 4)) line_q.push_back(word_char());
          if ($urandom_range(0, 3) != 0) line_q.push_back(CH_HASH);
        end
        8:  line_q.push_back(byte_t'($urandom_range(0, 255)));
        9:  line_q.push_back($urandom_range(0, 1) ? CH_DOT : CH_APOS);
        10: line_q.push_back(CH_NUL);
        default: line_q.push_back(CH_HYPHEN);
      endcase
    end
  endfunction

  task automatic send_byte(stim_row_t row);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= row.c;
    in_if.line_end <= row.fin;
    do @(posedge clk_i); while (!in_if.ready);
    normalize(row.c, row.fin);
    if (row.n < 0) begin
      foreach (step_q[k]) norm_q.push_back(step_q[k]);
    end else begin
      for (int k = 0; k < row.n; k++) norm_q.push_back(row.r[k]);
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (norm_q.size() != 0) @(negedge clk_i);
  endtask

  // output side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (long_hold_go && !hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    norm_char_t got;
    norm_char_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{ch: out_if.out_byte, last: out_if.out_last, ovf: out_if.word_overflow};
      if (norm_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual byte %h last %b ovf %b",
                 $time, got.ch, got.last, got.ovf);
        err_cnt++;
      end else begin
        want = norm_q.pop_front();
        if (got.ch !== want.ch || got.last !== want.last || got.ovf !== want.ovf) begin
          $display("%0t: mismatch, expected byte %h last %b ovf %b, actual byte %h last %b ovf %b",
                   $time, want.ch, want.last, want.ovf, got.ch, got.last, got.ovf);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        sent;
    in_if.valid    <= 1'b0;
    in_if.in_byte  <= CH_NUL;
    in_if.line_end <= 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_row(CH_NUL, 1'b1, 1, plain(CH_NUL, 1'b1));
    add_row(8'hFF, 1'b1, 2, plain(8'hFF, 1'b0), plain(CH_NUL, 1'b1));
    add_row("a", 1'b0, 0);
    add_row("z", 1'b0, 0);
    add_row(CH_SPACE, 1'b0, 3, plain("A", 1'b0), plain("Z", 1'b0), plain(CH_SPACE, 1'b0));
    add_row(CH_LPAR, 1'b0, 0);
    add_row(CH_RBRK, 1'b0, 0);
    add_row(CH_COLON, 1'b0, 0);
    add_row(CH_QUEST, 1'b0, 0);
    add_row(CH_BANG, 1'b0, 0);
    add_row(CH_LF, 1'b0, 0);
    add_row(CH_COMMA, 1'b0, 1, plain(CH_SPACE, 1'b0));
    add_row(CH_BSLASH, 1'b0, 1, plain(CH_SPACE, 1'b0));
    // comment span, then the byte after the closing mark
    add_row(CH_HASH, 1'b0, 0);
    add_row("x", 1'b0, 0);
    add_row(CH_HASH, 1'b0, 0);
    add_row("b", 1'b0, -1);
    add_row(CH_HYPHEN, 1'b0, -1);
    add_row(CH_SPACE, 1'b0, -1);
    add_row(CH_DOT, 1'b0, -1);
    add_row(CH_APOS, 1'b1, -1);
    // hyphen deletion with no space yet in the line
    add_row("q", 1'b0, -1);
    add_row(CH_HYPHEN, 1'b0, -1);
    add_row(CH_TAB, 1'b1, -1);
    add_row(CH_HYPHEN, 1'b1, 2, plain(CH_HYPHEN, 1'b0), plain(CH_NUL, 1'b1));
    add_row(CH_HYPHEN, 1'b0, -1);
    add_row(CH_NUL, 1'b0, -1);
    add_row(CH_HASH, 1'b0, -1);
    add_row("k", 1'b1, -1);

    foreach (dir_q[i]) send_byte(dir_q[i]);
    pause_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        gen_line();
        foreach (line_q[i]) begin
          row.c   = line_q[i];
          row.fin = (i == line_q.size() - 1);
          row.n   = -1;
          send_byte(row);
          sent++;
          if (ph == 0 && sent == 10) long_hold_go = 1'b1;
        end
      end
      pause_until_drained();
    end

    repeat (64) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
